@@ hdl/rcfe_pkg.sv @@
// Shared types and constants for the stick-channel frame encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rcfe_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MIN_VALUE     = 3'd0;
  localparam logic [2:0] REG_MAX_VALUE     = 3'd1;
  localparam logic [2:0] REG_SOURCE_BYTE   = 3'd2;
  localparam logic [2:0] REG_DEST_BYTE     = 3'd3;
  localparam logic [2:0] REG_KIND_BYTE     = 3'd4;
  localparam logic [2:0] REG_RESPONSE_BYTE = 3'd5;
  localparam logic [2:0] REG_ID_BYTE       = 3'd6;

  // Configuration reset values
  localparam logic signed [12:0] MIN_VALUE_RST = -13'sd1600;
  localparam logic signed [12:0] MAX_VALUE_RST = 13'sd1600;
  localparam logic [7:0]         ID_BYTE_RST   = 8'd200;

  // Frame marker bytes
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CHAR_M      = 8'h4D;  // 'M'
  localparam logic [7:0] CHAR_LT     = 8'h3C;  // '<'

  // 6*v/16 + 1500 rounded half up = floor((3*v + 8*1500 + 4) / 8)
  localparam logic signed [16:0] SCALE_BIAS = 17'sd12004;

  // Byte positions within one channel's request on the output side
  localparam logic [3:0] STEP_SRC  = 4'd0;
  localparam logic [3:0] STEP_DST  = 4'd1;
  localparam logic [3:0] STEP_KIND = 4'd2;
  localparam logic [3:0] STEP_RESP = 4'd3;
  localparam logic [3:0] STEP_DLR  = 4'd4;
  localparam logic [3:0] STEP_M    = 4'd5;
  localparam logic [3:0] STEP_LT   = 4'd6;
  localparam logic [3:0] STEP_LEN  = 4'd7;
  localparam logic [3:0] STEP_ID   = 4'd8;
  localparam logic [3:0] STEP_LO   = 4'd9;
  localparam logic [3:0] STEP_HI   = 4'd10;
  localparam logic [3:0] STEP_CKS  = 4'd11;

  typedef struct packed {
    logic signed [12:0] min_value;
    logic signed [12:0] max_value;
    logic [7:0]         source_byte;
    logic [7:0]         dest_byte;
    logic [7:0]         kind_byte;
    logic [7:0]         response_byte;
    logic [7:0]         id_byte;
  } cfg_t;

  // One classified channel waiting for the back end
  typedef struct packed {
    logic [15:0] scaled;
    logic        warn;
    logic        first;
    logic        last;
  } entry_t;

endpackage

@@ hdl/rcfe_front.sv @@
// Front end: accepts channel values, clamps and scales them, and tags frame position.
// Depends on rcfe_pkg.
module rcfe_front #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rcfe_pkg::cfg_t      cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic signed [12:0]  channel_value,
  input  logic                q_full,
  output logic                q_push,
  output rcfe_pkg::entry_t    q_entry
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic signed [12:0] v_cl;
  logic               warn;
  logic signed [16:0] num;
  logic signed [16:0] q;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // Clamp, upper bound first
  always_comb begin
    v_cl = channel_value;
    warn = 1'b0;
    if (channel_value > cfg.max_value) begin
      v_cl = cfg.max_value;
      warn = 1'b1;
    end else if (channel_value < cfg.min_value) begin
      v_cl = cfg.min_value;
      warn = 1'b1;
    end
  end

  // Scale by 3/8 with half-up rounding; floor through arithmetic shift
  assign num = (17'(v_cl) <<< 1) + 17'(v_cl) + rcfe_pkg::SCALE_BIAS;
  assign q   = num >>> 3;

  assign q_entry.scaled = q[15:0];
  assign q_entry.warn   = warn;
  assign q_entry.first  = (idx_r == '0);
  assign q_entry.last   = (idx_r == IDX_LAST);

  // Advance the channel position on each accepted request
  always_comb begin
    idx_nxt = idx_r;
    if (q_push) begin
      if (idx_r == IDX_LAST) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ hdl/rcfe_queue.sv @@
// Short show-ahead queue between the front and back ends.
// Depends on rcfe_pkg for the entry type.
module rcfe_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rcfe_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output rcfe_pkg::entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rcfe_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ hdl/rcfe_back.sv @@
// Back end: emits queued channel payloads with frame header and checksum bytes.
// Depends on rcfe_pkg; drives the registered output stream.
module rcfe_back #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rcfe_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  rcfe_pkg::entry_t head_entry,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_byte,
  output logic             frame_last,
  output logic             clamp_warning
);

  localparam logic [7:0] LEN_BYTE = 8'((2 * NUM_CHANNELS) % 256);

  logic       started_r, started_nxt;
  logic [3:0] step_r, step_nxt;
  logic [7:0] cks_r, cks_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_warn_r;
  logic       load;
  logic [3:0] eff_step;
  logic [3:0] final_step;
  logic [7:0] byte_sel;

  assign load       = head_valid && (!out_valid_r || out_tready);
  assign eff_step   = started_r ? step_r :
                      (head_entry.first ? rcfe_pkg::STEP_SRC : rcfe_pkg::STEP_LO);
  assign final_step = head_entry.last ? rcfe_pkg::STEP_CKS : rcfe_pkg::STEP_HI;
  assign pop        = load && (eff_step == final_step);

  // Pick the byte for the current position
  always_comb begin
    unique case (eff_step)
      rcfe_pkg::STEP_SRC:  byte_sel = cfg.source_byte;
      rcfe_pkg::STEP_DST:  byte_sel = cfg.dest_byte;
      rcfe_pkg::STEP_KIND: byte_sel = cfg.kind_byte;
      rcfe_pkg::STEP_RESP: byte_sel = cfg.response_byte;
      rcfe_pkg::STEP_DLR:  byte_sel = rcfe_pkg::CHAR_DOLLAR;
      rcfe_pkg::STEP_M:    byte_sel = rcfe_pkg::CHAR_M;
      rcfe_pkg::STEP_LT:   byte_sel = rcfe_pkg::CHAR_LT;
      rcfe_pkg::STEP_LEN:  byte_sel = LEN_BYTE;
      rcfe_pkg::STEP_ID:   byte_sel = cfg.id_byte;
      rcfe_pkg::STEP_LO:   byte_sel = head_entry.scaled[7:0];
      rcfe_pkg::STEP_HI:   byte_sel = head_entry.scaled[15:8];
      rcfe_pkg::STEP_CKS:  byte_sel = cks_r;
      default:             byte_sel = 8'h00;
    endcase
  end

  // Sequence position, checksum and output valid
  always_comb begin
    started_nxt   = started_r;
    step_nxt      = step_r;
    cks_nxt       = cks_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (pop) begin
        started_nxt = 1'b0;
      end else begin
        started_nxt = 1'b1;
        step_nxt    = eff_step + 4'd1;
      end
      case (eff_step) inside
        rcfe_pkg::STEP_LEN: cks_nxt = LEN_BYTE;
        rcfe_pkg::STEP_ID:  cks_nxt = cks_r ^ cfg.id_byte;
        rcfe_pkg::STEP_LO,
        rcfe_pkg::STEP_HI:  cks_nxt = cks_r ^ byte_sel;
        default:            cks_nxt = cks_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      step_r      <= rcfe_pkg::STEP_SRC;
      cks_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      step_r      <= step_nxt;
      cks_r       <= cks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold output payload until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= byte_sel;
      out_last_r <= (eff_step == rcfe_pkg::STEP_CKS);
      out_warn_r <= head_entry.warn;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_byte      = out_data_r;
  assign frame_last    = out_last_r;
  assign clamp_warning = out_warn_r;

endmodule

@@ hdl/rc_channel_frame_encoder_top.sv @@
// Top level of the stick-channel frame encoder: configuration registers and
// the front / queue / back chain. Depends on rcfe_pkg, rcfe_front, rcfe_queue, rcfe_back.
//
//  channel | direction | handshake           | payload
//  in_     | slave     | in_tvalid/in_tready | in_tdata[12:0] channel_value
//  out_    | master    | out_tvalid/tready   | tdata out_byte, tlast frame_last,
//          |           |                     | tuser clamp_warning
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data[12:0]
//
// The back end emits one byte per cycle while the output is ready and the queue holds
// an entry: 2 per channel, 9 more before the first channel of a frame and 1 more after
// the last, so a frame of N channels has 2*N+10 bytes (42 at 16 channels).
// Clamp and scale are combinational in the front; a 4-entry queue lets the front
// run ahead while the output stalls. Reset is synchronous and clears all control
// state; configuration writes are taken every cycle.
module rc_channel_frame_encoder_top #(
  parameter int NUM_CHANNELS = 16,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [12:0] channel_value, [15:13] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // frame_last
  output logic        out_tuser,  // [0] clamp_warning
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  rcfe_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             q_full;
  logic             q_push;
  rcfe_pkg::entry_t q_entry;
  logic             q_pop;
  logic             head_valid;
  rcfe_pkg::entry_t head_entry;

  assign cfg_ready = 1'b1;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcfe_pkg::REG_MIN_VALUE:     cfg_nxt.min_value     = signed'(cfg_data);
        rcfe_pkg::REG_MAX_VALUE:     cfg_nxt.max_value     = signed'(cfg_data);
        rcfe_pkg::REG_SOURCE_BYTE:   cfg_nxt.source_byte   = cfg_data[7:0];
        rcfe_pkg::REG_DEST_BYTE:     cfg_nxt.dest_byte     = cfg_data[7:0];
        rcfe_pkg::REG_KIND_BYTE:     cfg_nxt.kind_byte     = cfg_data[7:0];
        rcfe_pkg::REG_RESPONSE_BYTE: cfg_nxt.response_byte = cfg_data[7:0];
        rcfe_pkg::REG_ID_BYTE:       cfg_nxt.id_byte       = cfg_data[7:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value     <= rcfe_pkg::MIN_VALUE_RST;
      cfg_r.max_value     <= rcfe_pkg::MAX_VALUE_RST;
      cfg_r.source_byte   <= 8'h00;
      cfg_r.dest_byte     <= 8'h00;
      cfg_r.kind_byte     <= 8'h00;
      cfg_r.response_byte <= 8'h00;
      cfg_r.id_byte       <= rcfe_pkg::ID_BYTE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcfe_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .channel_value (signed'(in_tdata[12:0])),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  rcfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  rcfe_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .pop           (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_byte      (out_tdata),
    .frame_last    (out_tlast),
    .clamp_warning (out_tuser)
  );

endmodule

@@ hdl/rcfe_checker.sv @@
// Port-level checks for the stick-channel frame encoder, bound to the top level.
// Depends on rc_channel_frame_encoder_top's port list only.
module rcfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser,
  input logic       cfg_ready
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Stalled output request holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output changed");

  // A frame is never a single byte: two checksum bytes cannot be taken back to back
  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !(out_tvalid && out_tready && out_tlast))
    else $error("consecutive frame ends");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind rc_channel_frame_encoder_top rcfe_checker u_rcfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser),
  .cfg_ready  (cfg_ready)
);

@@ verif/tb_rc_channel_frame_encoder_top.sv @@
// Testbench for rc_channel_frame_encoder_top: drives channel values and register writes,
// predicts every outgoing frame byte and checks each one in order.
// Depends on rcfe_pkg and the RTL of the encoder only.
module tb_rc_channel_frame_encoder_top;

  localparam int          FRAME_CHANNELS = 16;
  localparam int          HALF_UP_BIAS   = 8 * 1500 + 4;  // 1500 and half an lsb, in eighths
  localparam logic [2:0]  REG_UNUSED     = 3'd7;
  localparam int          LONG_HOLD      = 300;
  localparam int          PHASE_ITEMS    = 57;
  localparam int          NUM_PHASES     = 8;

  // Frame byte predictor and in-order checker
  class rc_frame_tracker;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       warn;
    } frame_byte_t;

    logic signed [12:0] lo_bound;
    logic signed [12:0] hi_bound;
    logic [7:0]         route [4];
    logic [7:0]         msg_id;
    int unsigned        chan_pos;
    logic [7:0]         xor_acc;
    frame_byte_t        expected_bytes [$];
    int unsigned        errors;

    function new();
      lo_bound = rcfe_pkg::MIN_VALUE_RST;
      hi_bound = rcfe_pkg::MAX_VALUE_RST;
      foreach (route[i]) route[i] = 8'd0;
      msg_id   = rcfe_pkg::ID_BYTE_RST;
      chan_pos = 0;
      xor_acc  = 8'd0;
      errors   = 0;
    endfunction

    // Mirror a register write; unknown indexes are dropped
    function void set_reg(logic [2:0] idx, logic [12:0] data);
      case (idx)
        rcfe_pkg::REG_MIN_VALUE:     lo_bound = data;
        rcfe_pkg::REG_MAX_VALUE:     hi_bound = data;
        rcfe_pkg::REG_SOURCE_BYTE:   route[0] = data[7:0];
        rcfe_pkg::REG_DEST_BYTE:     route[1] = data[7:0];
        rcfe_pkg::REG_KIND_BYTE:     route[2] = data[7:0];
        rcfe_pkg::REG_RESPONSE_BYTE: route[3] = data[7:0];
        rcfe_pkg::REG_ID_BYTE:       msg_id   = data[7:0];
        default: ;
      endcase
    endfunction

    function void push_byte(logic [7:0] data, logic last, logic warn);
      frame_byte_t fb;
      fb.data = data;
      fb.last = last;
      fb.warn = warn;
      expected_bytes.insert(expected_bytes.size(), fb);
    endfunction

    // Clamp, scale and frame one accepted channel value
    function void note_channel(logic [12:0] raw);
      logic signed [12:0] v;
      logic               warn;
      int                 num;
      logic [15:0]        scaled;
      logic [7:0]         frame_len;
      v    = raw;
      warn = 1'b0;
      // upper bound wins when the bounds are crossed
      if (v > hi_bound) begin
        v    = hi_bound;
        warn = 1'b1;
      end else if (v < lo_bound) begin
        v    = lo_bound;
        warn = 1'b1;
      end
      num    = 3 * int'(v) + HALF_UP_BIAS;
      scaled = 16'(num >>> 3);
      frame_len = 8'(2 * FRAME_CHANNELS);
      if (chan_pos == 0) begin
        foreach (route[i]) push_byte(route[i], 1'b0, warn);
        push_byte(rcfe_pkg::CHAR_DOLLAR, 1'b0, warn);
        push_byte(rcfe_pkg::CHAR_M, 1'b0, warn);
        push_byte(rcfe_pkg::CHAR_LT, 1'b0, warn);
        push_byte(frame_len, 1'b0, warn);
        push_byte(msg_id, 1'b0, warn);
        xor_acc = frame_len ^ msg_id;
      end
      push_byte(scaled[7:0], 1'b0, warn);
      push_byte(scaled[15:8], 1'b0, warn);
      xor_acc = xor_acc ^ scaled[7:0] ^ scaled[15:8];
      chan_pos++;
      if (chan_pos == FRAME_CHANNELS) begin
        push_byte(xor_acc, 1'b1, warn);
        chan_pos = 0;
        xor_acc  = 8'd0;
      end
    endfunction

    // Compare one accepted output byte with the oldest prediction
    function void check_byte(logic [7:0] data, logic last, logic warn);
      frame_byte_t fb;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %h (tlast %b, tuser %b)", data, last, warn);
        errors++;
        return;
      end
      fb = expected_bytes.pop_front();
      if (data !== fb.data) begin
        $error("out_byte: expected %h, got %h", fb.data, data);
        errors++;
      end
      if (last !== fb.last) begin
        $error("frame_last: expected %b, got %b", fb.last, last);
        errors++;
      end
      if (warn !== fb.warn) begin
        $error("clamp_warning: expected %b, got %b", fb.warn, warn);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  rc_frame_tracker frames = new();
  bit              hold_request = 1'b0;
  int unsigned     burst_left   = 0;
  int              phase_lo     = -1600;
  int              phase_hi     = 1600;

  rc_channel_frame_encoder_top #(
    .NUM_CHANNELS(FRAME_CHANNELS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Check every accepted output request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      frames.check_byte(out_tdata, out_tlast, out_tuser);
  end

  // Output stalls: a randomly chosen ready pattern, plus one long hold on request
  initial begin
    int unsigned cyc;
    int unsigned mode;
    cyc  = 0;
    mode = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= (cyc % 4 == 0);
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Offer one channel value, idling between bursts; returns on a falling edge
  task automatic offer_channel(input logic [12:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, v};
    do @(posedge clk); while (!in_tready);
    frames.note_channel(v);
    @(negedge clk);
  endtask

  // Drop the input request and wait for every predicted byte to leave
  task automatic settle();
    in_tvalid <= 1'b0;
    while (frames.pending() != 0) @(negedge clk);
  endtask

  // Write one register; the caller drops cfg_valid after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    frames.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Load the register set of one random phase while the block is idle
  task automatic load_settings(input int unsigned phase);
    logic [12:0] fill [5];
    settle();
    foreach (fill[i]) fill[i] = 13'($urandom_range(0, 8191));
    case (phase)
      0: begin
        phase_lo = -4000;
        phase_hi = 4095;
        foreach (fill[i]) fill[i] = 13'h1FFF;
        fill[4] = 13'h1F00;
      end
      1: begin
        // lower bound at the bottom of the field range drives the scaled value negative
        phase_lo = -4096;
        phase_hi = 4095;
        foreach (fill[i]) fill[i] = 13'h0000;
        fill[4] = 13'h00FF;
      end
      2: begin
        phase_lo = 0;
        phase_hi = 0;
      end
      3: begin
        phase_lo = 4095;
        phase_hi = -4000;
      end
      4: begin
        phase_lo = -1600;
        phase_hi = 1600;
      end
      default: begin
        phase_lo = int'($urandom_range(0, 8095)) - 4000;
        phase_hi = int'($urandom_range(0, 8095)) - 4000;
      end
    endcase
    write_reg(rcfe_pkg::REG_MIN_VALUE, 13'(phase_lo));
    write_reg(rcfe_pkg::REG_MAX_VALUE, 13'(phase_hi));
    write_reg(rcfe_pkg::REG_SOURCE_BYTE, fill[0]);
    write_reg(rcfe_pkg::REG_DEST_BYTE, fill[1]);
    write_reg(rcfe_pkg::REG_KIND_BYTE, fill[2]);
    write_reg(rcfe_pkg::REG_RESPONSE_BYTE, fill[3]);
    write_reg(rcfe_pkg::REG_ID_BYTE, fill[4]);
    if (phase == 4) write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));
    cfg_valid <= 1'b0;
  endtask

  // Channel value biased toward the clamp bounds and the field extremes
  function automatic logic [12:0] pick_channel();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 13'($urandom_range(0, 8191));
      4, 5:       return 13'(phase_lo + int'($urandom_range(0, 4)) - 2);
      6, 7:       return 13'(phase_hi + int'($urandom_range(0, 4)) - 2);
      8:          return ($urandom_range(0, 1) == 1) ? 13'h1000 : 13'h0FFF;
      default:    return 13'(int'($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  initial begin
    int directed_vals [25];
    directed_vals = '{-4096, 4095, 0, -1, 1600, 1601, -1600, -1601, 4, -4, 1, 8,
                      2730, -2731, 100, -100, 3, -3, 5, -5,
                      2000, -2000, 0, -1000, 1000};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 16'd0;
    cfg_valid = 1'b0;
    cfg_index = rcfe_pkg::REG_MIN_VALUE;
    cfg_data  = 13'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: a full frame and the start of the next, with extremes, bounds and rounding ties
    for (int i = 0; i < 20; i++) offer_channel(13'(directed_vals[i]));

    // Change the id mid-frame and cross the bounds
    settle();
    write_reg(rcfe_pkg::REG_ID_BYTE, 13'h005A);
    write_reg(rcfe_pkg::REG_MIN_VALUE, 13'(1000));
    write_reg(rcfe_pkg::REG_MAX_VALUE, 13'(-1000));
    cfg_valid <= 1'b0;
    for (int i = 20; i < 25; i++) offer_channel(13'(directed_vals[i]));

    // Random phases, each with its own register set
    for (int p = 0; p < NUM_PHASES; p++) begin
      load_settings(p);
      if (p == 1) hold_request = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) offer_channel(pick_channel());
    end

    settle();
    repeat (20) @(negedge clk);
    if (frames.errors == 0 && frames.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
